// ----- src/bpru_pkg.sv -----
// Shared types, codes and tables for the BMP pixel row unpacker.
// No dependencies; every other file imports this package.
package bpru_pkg;

  // Field and counter widths
  localparam int DIM_W      = 13;
  localparam int RBC_W      = 15;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 13;

  // Default sizes
  localparam int DEF_MAX_WIDTH     = 4096;
  localparam int DEF_MAX_HEIGHT    = 4096;
  localparam int DEF_PALETTE_DEPTH = 256;

  // Input word operation codes
  localparam logic OP_PIXEL   = 1'b0;
  localparam logic OP_PALETTE = 1'b1;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_PIXEL_FORMAT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd2;

  // Pixel format codes
  typedef enum logic [2:0] {
    FMT_1BPP  = 3'd0,
    FMT_2BPP  = 3'd1,
    FMT_4BPP  = 3'd2,
    FMT_8BPP  = 3'd3,
    FMT_16BPP = 3'd4,
    FMT_24BPP = 3'd5,
    FMT_32BPP = 3'd6,
    FMT_RSVD  = 3'd7
  } fmt_t;

  localparam logic [7:0] ALPHA_OPAQUE = 8'hFF;

  typedef struct packed {
    logic       operation;
    logic [7:0] data_byte;
    logic [7:0] palette_index;
    logic [7:0] palette_red;
    logic [7:0] palette_green;
    logic [7:0] palette_blue;
  } in_word_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
    logic       row_end;
    logic       image_end;
    logic       last_of_run;
  } out_word_t;

  // One pixel issued by the byte sequencer toward the output stage
  typedef struct packed {
    logic        direct;
    logic        oob;
    logic [23:0] rgb;
    logic [7:0]  alpha;
    logic        row_end;
    logic        image_end;
    logic        last_of_run;
  } pix_ctl_t;

  // floor(x * 255 / 31) for a 5-bit field
  localparam logic [7:0] SCALE5_LUT [32] = '{
    8'd0,   8'd8,   8'd16,  8'd24,  8'd32,  8'd41,  8'd49,  8'd57,
    8'd65,  8'd74,  8'd82,  8'd90,  8'd98,  8'd106, 8'd115, 8'd123,
    8'd131, 8'd139, 8'd148, 8'd156, 8'd164, 8'd172, 8'd180, 8'd189,
    8'd197, 8'd205, 8'd213, 8'd222, 8'd230, 8'd238, 8'd246, 8'd255
  };

endpackage

// ----- src/bpru_palette.sv -----
// Palette memory: one write port, one registered read port.
// Depends on bpru_pkg for DEF_PALETTE_DEPTH; sized by PALETTE_DEPTH.
module bpru_palette import bpru_pkg::*; #(
  parameter int PALETTE_DEPTH = DEF_PALETTE_DEPTH,
  localparam int AW = $clog2(PALETTE_DEPTH)
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [23:0]   wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [23:0]   rdata
);

  logic [23:0] mem [PALETTE_DEPTH];
  logic [23:0] rdata_r;

  // Write entry, read-first on the read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ----- src/bpru_byte_ctl.sv -----
// Configuration registers, row/byte counters and the per-byte pixel sequencer.
// Depends on bpru_pkg; drives the palette ports and feeds bpru_pixel_out.
module bpru_byte_ctl import bpru_pkg::*; #(
  parameter int MAX_WIDTH     = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT    = DEF_MAX_HEIGHT,
  parameter int PALETTE_DEPTH = DEF_PALETTE_DEPTH,
  localparam int AW = $clog2(PALETTE_DEPTH)
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  in_word_t              in_data,
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  take,
  output logic                  emit_valid,
  output pix_ctl_t              emit_ctl,
  output logic                  pal_we,
  output logic [AW-1:0]         pal_waddr,
  output logic [23:0]           pal_wdata,
  output logic                  pal_re,
  output logic [AW-1:0]         pal_raddr
);

  // Configuration
  fmt_t             fmt_r;
  logic [DIM_W-1:0] width_r, height_r;
  logic [DIM_W-1:0] width_cl, height_cl;

  // Stream state
  logic [RBC_W-1:0] rbc_r, rbc_nxt;
  logic [DIM_W-1:0] rpc_r, rpc_nxt;
  logic [DIM_W-1:0] rc_r, rc_nxt;
  logic [23:0]      gather_r, gather_nxt;
  logic [1:0]       phase_r, phase_nxt;

  // Sequencer
  logic             busy_r, busy_nxt;
  logic             direct_r, direct_nxt;
  logic [7:0]       sh_r, sh_nxt;
  logic [3:0]       cnt_r, cnt_nxt;
  logic [DIM_W-1:0] pix_r, pix_nxt;
  logic [DIM_W-1:0] snap_rc_r, snap_rc_nxt;
  logic [23:0]      color_r, color_nxt;
  logic [7:0]       alpha_r, alpha_nxt;

  logic             in_fire, emit_fire, last_pix, pix_byte;
  logic [17:0]      row_bits;
  logic [RBC_W-1:0] row_bytes, padded, rbc_inc;
  logic [3:0]       per_byte, n_pix;
  logic [DIM_W-1:0] remain;
  logic [1:0]       phase_last;
  logic [15:0]      word16;
  logic [7:0]       idx;
  logic             row_end;

  // Clamp written dimensions to 1 .. MAX
  always_comb begin
    if (cfg_data == '0) begin
      width_cl = DIM_W'(1);
    end else if (cfg_data > MAX_WIDTH) begin
      width_cl = DIM_W'(MAX_WIDTH);
    end else begin
      width_cl = cfg_data;
    end
    if (cfg_data == '0) begin
      height_cl = DIM_W'(1);
    end else if (cfg_data > MAX_HEIGHT) begin
      height_cl = DIM_W'(MAX_HEIGHT);
    end else begin
      height_cl = cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fmt_r    <= FMT_1BPP;
      width_r  <= DIM_W'(1);
      height_r <= DIM_W'(1);
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_PIXEL_FORMAT: fmt_r    <= fmt_t'(cfg_data[2:0]);
        REG_IMAGE_WIDTH:  width_r  <= width_cl;
        REG_IMAGE_HEIGHT: height_r <= height_cl;
        default: ;
      endcase
    end
  end

  // Padded row length in bytes
  always_comb begin
    unique case (fmt_r)
      FMT_1BPP:  row_bits = 18'(width_r);
      FMT_2BPP:  row_bits = 18'(width_r) << 1;
      FMT_4BPP:  row_bits = 18'(width_r) << 2;
      FMT_8BPP:  row_bits = 18'(width_r) << 3;
      FMT_16BPP: row_bits = 18'(width_r) << 4;
      FMT_24BPP: row_bits = (18'(width_r) << 4) + (18'(width_r) << 3);
      FMT_32BPP: row_bits = 18'(width_r) << 5;
      default:   row_bits = '0;
    endcase
    row_bytes = RBC_W'((row_bits + 18'd7) >> 3);
    padded    = RBC_W'(row_bytes + RBC_W'(3)) & ~RBC_W'(3);
  end

  // Current palette index out of the shifted byte
  always_comb begin
    unique case (fmt_r)
      FMT_1BPP: begin
        idx    = 8'(sh_r[7]);
        sh_nxt = sh_r << 1;
      end
      FMT_2BPP: begin
        idx    = 8'(sh_r[7:6]);
        sh_nxt = sh_r << 2;
      end
      FMT_4BPP: begin
        idx    = 8'(sh_r[7:4]);
        sh_nxt = sh_r << 4;
      end
      default: begin
        idx    = sh_r;
        sh_nxt = sh_r;
      end
    endcase
  end

  // Handshakes
  assign last_pix   = (cnt_r == 4'd1);
  assign emit_fire  = busy_r && take;
  assign in_ready   = !busy_r || (emit_fire && last_pix);
  assign in_fire    = in_valid && in_ready;
  assign pix_byte   = in_fire && (in_data.operation == OP_PIXEL) &&
                      (fmt_r != FMT_RSVD) && (rc_r < height_r);

  // Palette write port
  assign pal_we    = in_fire && (in_data.operation == OP_PALETTE) &&
                     (in_data.palette_index < PALETTE_DEPTH);
  assign pal_waddr = in_data.palette_index[AW-1:0];
  assign pal_wdata = {in_data.palette_red, in_data.palette_green, in_data.palette_blue};

  // Palette read and pixel issue
  assign row_end   = (DIM_W'(pix_r + 1'b1) == width_r);
  assign pal_re    = emit_fire && !direct_r;
  assign pal_raddr = idx[AW-1:0];
  assign emit_valid = busy_r;
  always_comb begin
    emit_ctl.direct      = direct_r;
    emit_ctl.oob         = (idx >= PALETTE_DEPTH);
    emit_ctl.rgb         = color_r;
    emit_ctl.alpha       = alpha_r;
    emit_ctl.row_end     = row_end;
    emit_ctl.image_end   = row_end && (DIM_W'(snap_rc_r + 1'b1) == height_r);
    emit_ctl.last_of_run = last_pix;
  end

  // Stream counters and sequencer load
  always_comb begin
    rbc_nxt     = rbc_r;
    rpc_nxt     = rpc_r;
    rc_nxt      = rc_r;
    gather_nxt  = gather_r;
    phase_nxt   = phase_r;
    busy_nxt    = busy_r;
    direct_nxt  = direct_r;
    cnt_nxt     = cnt_r;
    pix_nxt     = pix_r;
    snap_rc_nxt = snap_rc_r;
    color_nxt   = color_r;
    alpha_nxt   = alpha_r;
    per_byte    = 4'd8 >> fmt_r;
    remain      = width_r - rpc_r;
    n_pix       = (remain < DIM_W'(per_byte)) ? remain[3:0] : per_byte;
    phase_last  = 2'(fmt_r - FMT_8BPP);
    word16      = {in_data.data_byte, gather_r[7:0]};
    rbc_inc     = RBC_W'(rbc_r + 1'b1);

    // Advance sequencer on each issued pixel
    if (emit_fire) begin
      cnt_nxt = cnt_r - 4'd1;
      pix_nxt = DIM_W'(pix_r + 1'b1);
      if (last_pix) begin
        busy_nxt = 1'b0;
      end
    end

    if (pix_byte) begin
      if (rpc_r < width_r) begin
        if (fmt_r <= FMT_8BPP) begin
          busy_nxt    = 1'b1;
          direct_nxt  = 1'b0;
          cnt_nxt     = n_pix;
          pix_nxt     = rpc_r;
          snap_rc_nxt = rc_r;
          alpha_nxt   = ALPHA_OPAQUE;
          rpc_nxt     = DIM_W'(rpc_r + n_pix);
        end else if (phase_r < phase_last) begin
          // Gather the next byte of a multi-byte pixel
          case (phase_r)
            2'd0:    gather_nxt[7:0]   = in_data.data_byte;
            2'd1:    gather_nxt[15:8]  = in_data.data_byte;
            default: gather_nxt[23:16] = in_data.data_byte;
          endcase
          phase_nxt = 2'(phase_r + 1'b1);
        end else begin
          busy_nxt    = 1'b1;
          direct_nxt  = 1'b1;
          cnt_nxt     = 4'd1;
          pix_nxt     = rpc_r;
          snap_rc_nxt = rc_r;
          rpc_nxt     = DIM_W'(rpc_r + 1'b1);
          gather_nxt  = '0;
          phase_nxt   = '0;
          case (fmt_r)
            FMT_16BPP: begin
              color_nxt = {SCALE5_LUT[word16[14:10]], SCALE5_LUT[word16[9:5]],
                           SCALE5_LUT[word16[4:0]]};
              alpha_nxt = ALPHA_OPAQUE;
            end
            FMT_24BPP: begin
              color_nxt = {in_data.data_byte, gather_r[15:8], gather_r[7:0]};
              alpha_nxt = ALPHA_OPAQUE;
            end
            default: begin
              color_nxt = gather_r;
              alpha_nxt = in_data.data_byte;
            end
          endcase
        end
      end
      // Drop padding and close the row
      if (rbc_inc >= padded) begin
        rbc_nxt    = '0;
        rpc_nxt    = '0;
        gather_nxt = '0;
        phase_nxt  = '0;
        rc_nxt     = DIM_W'(rc_r + 1'b1);
      end else begin
        rbc_nxt = rbc_inc;
      end
    end

    // Restart the stream on a write to the format, width or height register
    if (cfg_wr_en && (cfg_index == REG_PIXEL_FORMAT || cfg_index == REG_IMAGE_WIDTH ||
                      cfg_index == REG_IMAGE_HEIGHT)) begin
      rbc_nxt    = '0;
      rpc_nxt    = '0;
      rc_nxt     = '0;
      gather_nxt = '0;
      phase_nxt  = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rbc_r    <= '0;
      rpc_r    <= '0;
      rc_r     <= '0;
      gather_r <= '0;
      phase_r  <= '0;
      busy_r   <= 1'b0;
    end else begin
      rbc_r    <= rbc_nxt;
      rpc_r    <= rpc_nxt;
      rc_r     <= rc_nxt;
      gather_r <= gather_nxt;
      phase_r  <= phase_nxt;
      busy_r   <= busy_nxt;
    end
  end

  // Sequencer payload: load the byte or shift out one pixel's bits
  always_ff @(posedge clk) begin
    if (pix_byte) begin
      sh_r <= in_data.data_byte;
    end else if (emit_fire) begin
      sh_r <= sh_nxt;
    end
    direct_r  <= direct_nxt;
    cnt_r     <= cnt_nxt;
    pix_r     <= pix_nxt;
    snap_rc_r <= snap_rc_nxt;
    color_r   <= color_nxt;
    alpha_r   <= alpha_nxt;
  end

endmodule

// ----- src/bpru_pixel_out.sv -----
// Output stage aligned with the palette read data; selects the final color.
// Depends on bpru_pkg for pix_ctl_t and out_word_t.
module bpru_pixel_out import bpru_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        emit_valid,
  input  pix_ctl_t    emit_ctl,
  input  logic [23:0] pal_rdata,
  output logic        take,
  output logic        out_valid,
  input  logic        out_ready,
  output out_word_t   out_data
);

  logic     p_valid_r, p_valid_nxt;
  pix_ctl_t p_ctl_r, p_ctl_nxt;
  logic [23:0] rgb;

  // Advance when the output word is empty or being taken
  assign take = !p_valid_r || out_ready;

  always_comb begin
    p_valid_nxt = p_valid_r;
    p_ctl_nxt   = p_ctl_r;
    if (take) begin
      p_valid_nxt = emit_valid;
      p_ctl_nxt   = emit_ctl;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_valid_r <= 1'b0;
    end else begin
      p_valid_r <= p_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    p_ctl_r <= p_ctl_nxt;
  end

  // Pick direct color, palette entry, or black for an index past the palette
  always_comb begin
    if (p_ctl_r.direct) begin
      rgb = p_ctl_r.rgb;
    end else if (p_ctl_r.oob) begin
      rgb = '0;
    end else begin
      rgb = pal_rdata;
    end
    out_data.red         = rgb[23:16];
    out_data.green       = rgb[15:8];
    out_data.blue        = rgb[7:0];
    out_data.alpha       = p_ctl_r.alpha;
    out_data.row_end     = p_ctl_r.row_end;
    out_data.image_end   = p_ctl_r.image_end;
    out_data.last_of_run = p_ctl_r.last_of_run;
  end

  assign out_valid = p_valid_r;

endmodule

// ----- src/bmp_pixel_row_unpacker.sv -----
// BMP pixel array to RGBA8888, at most one result word per cycle while out_ready holds.
// A byte's first pixel passes the sequencer registers, loaded when the byte is accepted,
// then the palette read and output word registers, loaded when the output stage takes it.
// A byte yields up to 8/bpp pixels at 1, 2, 4, 8 bpp; 16/24/32 bpp and padding bytes are
// taken one per cycle while the output does not stall. Palette words are written on accept.
// Synchronous active-low reset clears counters, config and valids; palette is not cleared.
module bmp_pixel_row_unpacker import bpru_pkg::*; #(
  parameter int MAX_WIDTH     = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT    = DEF_MAX_HEIGHT,
  parameter int PALETTE_DEPTH = DEF_PALETTE_DEPTH
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  in_word_t              in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output out_word_t             out_data,
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int AW = $clog2(PALETTE_DEPTH);

  logic          take, emit_valid;
  pix_ctl_t      emit_ctl;
  logic          pal_we, pal_re;
  logic [AW-1:0] pal_waddr, pal_raddr;
  logic [23:0]   pal_wdata, pal_rdata;

  bpru_byte_ctl #(
    .MAX_WIDTH    (MAX_WIDTH),
    .MAX_HEIGHT   (MAX_HEIGHT),
    .PALETTE_DEPTH(PALETTE_DEPTH)
  ) u_byte_ctl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .take      (take),
    .emit_valid(emit_valid),
    .emit_ctl  (emit_ctl),
    .pal_we    (pal_we),
    .pal_waddr (pal_waddr),
    .pal_wdata (pal_wdata),
    .pal_re    (pal_re),
    .pal_raddr (pal_raddr)
  );

  bpru_palette #(
    .PALETTE_DEPTH(PALETTE_DEPTH)
  ) u_palette (
    .clk  (clk),
    .we   (pal_we),
    .waddr(pal_waddr),
    .wdata(pal_wdata),
    .re   (pal_re),
    .raddr(pal_raddr),
    .rdata(pal_rdata)
  );

  bpru_pixel_out u_pixel_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .emit_valid(emit_valid),
    .emit_ctl  (emit_ctl),
    .pal_rdata (pal_rdata),
    .take      (take),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

// ----- src/bpru_checker.sv -----
// Port-level checks on the unpacker's result channel, bound to the top level.
// Depends on bpru_pkg for out_word_t.
module bpru_checker import bpru_pkg::*; (
  input logic      clk,
  input logic      rst_n,
  input logic      out_valid,
  input logic      out_ready,
  input out_word_t out_data
);

  // Hold a stalled result word
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result word changed while stalled");

  // Image end only on a row end
  a_image_row: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.image_end |-> out_data.row_end)
    else $error("image end without row end");

  // A row end closes the run of its byte
  a_row_run: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.row_end |-> out_data.last_of_run)
    else $error("row end inside a run");

  // Drop results on reset
  a_reset_idle: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind bmp_pixel_row_unpacker bpru_checker u_checker (.*);
